### rtl/als_pkg.sv
// Shared types, codes and field widths for the adjacency list store.
package als_pkg;

  localparam int DEF_NODE_DEPTH = 256;
  localparam int DEF_EDGE_DEPTH = 64;

  localparam int ACTION_W  = 2;
  localparam int SCORE_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int PROD_W    = 32;
  localparam int NCOUNT_W  = 9;
  localparam int ECOUNT_W  = 7;
  localparam int LINK_IDX_W = 6;
  localparam int LINK_W    = LINK_IDX_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [NCOUNT_W-1:0] NODE_LIMIT_RST = 9'd256;
  localparam logic [ECOUNT_W-1:0] EDGE_LIMIT_RST = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_ADD_NODE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 2'd2;

  localparam logic [1:0] KIND_NODE      = 2'd0;
  localparam logic [1:0] KIND_EDGE      = 2'd1;
  localparam logic [1:0] KIND_NEIGHBOUR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT = 1'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic emit_node_ans;   // add node: write table if room, answer either way
    logic emit_edge_refuse;
    logic edge_start;      // read source node's chain head
    logic edge_commit;     // write edge, relink head, answer
    logic trav_start;      // read traversed node
    logic trav_head;       // latch score, fetch first edge
    logic trav_calc;       // multiply, fetch next edge
    logic trav_emit;       // load neighbour entry into output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic edge_bad;
    logic trav_bad;
    logic head_live;
    logic stage_last;
  } stat_t;

endpackage

### rtl/adjacency_list_store.sv
// Top level of the adjacency list graph store.
// Graph store with node and edge tables in RAM. Input items carry an action
// (add node, add edge, traverse) with score, src_index, dest_index and weight;
// a transfer takes place when in_valid is high and in_stall is low.
// Results leave on out_valid/out_stall with result_kind, ok, node_index,
// target_index, weighted_score and last; last marks an item's final result.
// Limits are written through cfg_valid/cfg_ready (always ready), cfg_index
// selecting node_limit or edge_limit, and cfg_data; write only while idle.
// Add node, and add edge when refused, answer at the accepting edge; add
// edge reads the source's chain head, then in EDGE_WR writes and relinks.
// A traverse reads the node; TRAV_HEAD latches its score and fetches the
// first edge; per neighbour TRAV_CALC multiplies and TRAV_EMIT emits.
// A new item is taken once the previous one is finished, while its last
// result may still sit in the output register.
// Reset clears the counts and restores both limits; the tables need no
// clearing pass, since no entry is reachable before it is written.
// While out_stall is high the output register holds and the walk pauses.
module adjacency_list_store #(
  parameter int NODE_DEPTH = als_pkg::DEF_NODE_DEPTH,
  parameter int EDGE_DEPTH = als_pkg::DEF_EDGE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [als_pkg::ACTION_W-1:0]       action,
  input  logic signed [als_pkg::SCORE_W-1:0] score,
  input  logic [als_pkg::INDEX_W-1:0]        src_index,
  input  logic [als_pkg::INDEX_W-1:0]        dest_index,
  input  logic signed [als_pkg::SCORE_W-1:0] weight,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         result_kind,
  output logic                               ok,
  output logic [als_pkg::INDEX_W-1:0]        node_index,
  output logic [als_pkg::INDEX_W-1:0]        target_index,
  output logic signed [als_pkg::PROD_W-1:0]  weighted_score,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [als_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0]     cfg_data
);

  als_pkg::cmd_t  cmd;
  als_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  als_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action  (action),
    .stat    (stat),
    .cmd     (cmd)
  );

  als_dp #(
    .NODE_DEPTH(NODE_DEPTH),
    .EDGE_DEPTH(EDGE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .score         (score),
    .src_index     (src_index),
    .dest_index    (dest_index),
    .weight        (weight),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .ok            (ok),
    .node_index    (node_index),
    .target_index  (target_index),
    .weighted_score(weighted_score),
    .last          (last)
  );

endmodule

### rtl/als_ram.sv
// Generic simple dual-port RAM with registered read.
module als_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/als_dp.sv
// Datapath: counters, limits, node and edge tables, multiplier and output register.
module als_dp #(
  parameter int NODE_DEPTH = als_pkg::DEF_NODE_DEPTH,
  parameter int EDGE_DEPTH = als_pkg::DEF_EDGE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  als_pkg::cmd_t                          cmd,
  output als_pkg::stat_t                         stat,
  input  logic signed [als_pkg::SCORE_W-1:0]     score,
  input  logic [als_pkg::INDEX_W-1:0]            src_index,
  input  logic [als_pkg::INDEX_W-1:0]            dest_index,
  input  logic signed [als_pkg::SCORE_W-1:0]     weight,
  input  logic                                   cfg_valid,
  input  logic [als_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             result_kind,
  output logic                                   ok,
  output logic [als_pkg::INDEX_W-1:0]            node_index,
  output logic [als_pkg::INDEX_W-1:0]            target_index,
  output logic signed [als_pkg::PROD_W-1:0]      weighted_score,
  output logic                                   last
);

  localparam int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int EAW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int NODE_W = als_pkg::SCORE_W + als_pkg::LINK_W;
  localparam int EDGE_W = als_pkg::INDEX_W + als_pkg::SCORE_W + als_pkg::LINK_W;

  logic [als_pkg::NCOUNT_W-1:0] node_limit;
  logic [als_pkg::ECOUNT_W-1:0] edge_limit;
  logic [als_pkg::NCOUNT_W-1:0] nodes_used;
  logic [als_pkg::ECOUNT_W-1:0] edges_used;

  logic [als_pkg::INDEX_W-1:0]        src_r;
  logic [als_pkg::INDEX_W-1:0]        dst_r;
  logic signed [als_pkg::SCORE_W-1:0] weight_r;
  logic signed [als_pkg::SCORE_W-1:0] score_r;
  logic signed [als_pkg::PROD_W-1:0]  prod_r;
  logic [als_pkg::INDEX_W-1:0]        tgt_r;
  logic                               last_r;

  logic              node_wr_en;
  logic [NAW-1:0]    node_wr_addr;
  logic [NODE_W-1:0] node_wr_data;
  logic              node_rd_en;
  logic [NODE_W-1:0] node_rd;
  logic              edge_rd_en;
  logic [EAW-1:0]    edge_rd_addr;
  logic [EDGE_W-1:0] edge_rd;

  logic [als_pkg::LINK_W-1:0]         head_link;
  logic [als_pkg::LINK_W-1:0]         next_link;
  logic signed [als_pkg::SCORE_W-1:0] node_score;
  logic signed [als_pkg::SCORE_W-1:0] e_weight;
  logic [als_pkg::INDEX_W-1:0]        e_target;
  logic head_live, next_live;
  logic node_full, edge_full;
  logic out_load;

  assign node_score = node_rd[NODE_W-1:als_pkg::LINK_W];
  assign head_link  = node_rd[als_pkg::LINK_W-1:0];
  assign e_target   = edge_rd[EDGE_W-1:EDGE_W-als_pkg::INDEX_W];
  assign e_weight   = edge_rd[als_pkg::SCORE_W+als_pkg::LINK_W-1:als_pkg::LINK_W];
  assign next_link  = edge_rd[als_pkg::LINK_W-1:0];

  // a link is followed only while its valid bit is set and it names a real slot
  assign head_live = head_link[als_pkg::LINK_W-1] &&
                     (32'(head_link[als_pkg::LINK_IDX_W-1:0]) < EDGE_DEPTH);
  assign next_live = next_link[als_pkg::LINK_W-1] &&
                     (32'(next_link[als_pkg::LINK_IDX_W-1:0]) < EDGE_DEPTH);

  assign node_full = (nodes_used >= node_limit) || (32'(nodes_used) >= NODE_DEPTH);
  assign edge_full = (edges_used >= edge_limit) || (32'(edges_used) >= EDGE_DEPTH);

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.edge_bad   = ({1'b0, src_index} >= nodes_used) ||
                           ({1'b0, dest_index} >= nodes_used) || edge_full;
  assign stat.trav_bad   = {1'b0, src_index} >= nodes_used;
  assign stat.head_live  = head_live;
  assign stat.stage_last = last_r;

  assign out_load = cmd.emit_node_ans || cmd.emit_edge_refuse ||
                    cmd.edge_commit || cmd.trav_emit;

  // node table port selection
  always_comb begin
    node_wr_en   = 1'b0;
    node_wr_addr = NAW'(nodes_used);
    node_wr_data = {score, als_pkg::LINK_W'(0)};
    if (cmd.emit_node_ans && !node_full) begin
      node_wr_en = 1'b1;
    end else if (cmd.edge_commit) begin
      node_wr_en   = 1'b1;
      node_wr_addr = NAW'(src_r);
      node_wr_data = {node_score, 1'b1, als_pkg::LINK_IDX_W'(edges_used)};
    end
  end

  assign node_rd_en = cmd.edge_start || cmd.trav_start;

  always_comb begin
    edge_rd_en   = 1'b0;
    edge_rd_addr = EAW'(head_link[als_pkg::LINK_IDX_W-1:0]);
    if (cmd.trav_head && head_live) begin
      edge_rd_en = 1'b1;
    end else if (cmd.trav_calc && next_live) begin
      edge_rd_en   = 1'b1;
      edge_rd_addr = EAW'(next_link[als_pkg::LINK_IDX_W-1:0]);
    end
  end

  als_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_DEPTH)
  ) u_node_ram (
    .clk    (clk),
    .wr_en  (node_wr_en),
    .wr_addr(node_wr_addr),
    .wr_data(node_wr_data),
    .rd_en  (node_rd_en),
    .rd_addr(NAW'(src_index)),
    .rd_data(node_rd)
  );

  als_ram #(
    .WIDTH(EDGE_W),
    .DEPTH(EDGE_DEPTH)
  ) u_edge_ram (
    .clk    (clk),
    .wr_en  (cmd.edge_commit),
    .wr_addr(EAW'(edges_used)),
    .wr_data({dst_r, weight_r, head_link}),
    .rd_en  (edge_rd_en),
    .rd_addr(edge_rd_addr),
    .rd_data(edge_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= als_pkg::NODE_LIMIT_RST;
      edge_limit <= als_pkg::EDGE_LIMIT_RST;
      nodes_used <= '0;
      edges_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          als_pkg::CFG_NODE_LIMIT: node_limit <= cfg_data;
          als_pkg::CFG_EDGE_LIMIT: edge_limit <= cfg_data[als_pkg::ECOUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.emit_node_ans && !node_full) begin
        nodes_used <= nodes_used + 1'b1;
      end
      if (cmd.edge_commit) begin
        edges_used <= edges_used + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.edge_start || cmd.trav_start) begin
      src_r    <= src_index;
      dst_r    <= dest_index;
      weight_r <= weight;
    end
    if (cmd.trav_head) begin
      score_r <= node_score;
    end
    if (cmd.trav_calc) begin
      prod_r <= score_r * e_weight;
      tgt_r  <= e_target;
      last_r <= !next_live;
    end
    if (cmd.emit_node_ans) begin
      result_kind    <= als_pkg::KIND_NODE;
      ok             <= !node_full;
      node_index     <= node_full ? '0 : nodes_used[als_pkg::INDEX_W-1:0];
      target_index   <= '0;
      weighted_score <= '0;
      last           <= 1'b1;
    end else if (cmd.emit_edge_refuse || cmd.edge_commit) begin
      result_kind    <= als_pkg::KIND_EDGE;
      ok             <= cmd.edge_commit;
      node_index     <= '0;
      target_index   <= '0;
      weighted_score <= '0;
      last           <= 1'b1;
    end else if (cmd.trav_emit) begin
      result_kind    <= als_pkg::KIND_NEIGHBOUR;
      ok             <= 1'b1;
      node_index     <= src_r;
      target_index   <= tgt_r;
      weighted_score <= prod_r;
      last           <= last_r;
    end
  end

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nodes_used) <= NODE_DEPTH)
    else $error("node count beyond table depth");

  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edges_used) <= EDGE_DEPTH)
    else $error("edge count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_valid) |-> !out_stall)
    else $error("output register loaded while its result is stalled");

  a_edge_count_step: assert property (@(posedge clk) disable iff (rst)
    (edges_used != $past(edges_used)) |-> $past(cmd.edge_commit))
    else $error("edge count moved without a commit");

endmodule

### rtl/als_ctrl.sv
// Controller state machine sequencing inserts and chain walks.
module als_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [als_pkg::ACTION_W-1:0]  action,
  input  als_pkg::stat_t                stat,
  output als_pkg::cmd_t                 cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EDGE_WR,
    TRAV_HEAD,
    TRAV_CALC,
    TRAV_EMIT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = !((state == IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          case (action)
            als_pkg::ACT_ADD_NODE: cmd.emit_node_ans = 1'b1;
            als_pkg::ACT_ADD_EDGE: begin
              if (stat.edge_bad) begin
                cmd.emit_edge_refuse = 1'b1;
              end else begin
                cmd.edge_start = 1'b1;
                state_next     = EDGE_WR;
              end
            end
            als_pkg::ACT_TRAVERSE: begin
              if (!stat.trav_bad) begin
                cmd.trav_start = 1'b1;
                state_next     = TRAV_HEAD;
              end
            end
            default: ;
          endcase
        end
      end
      EDGE_WR: begin
        if (stat.out_free) begin
          cmd.edge_commit = 1'b1;
          state_next      = IDLE;
        end
      end
      TRAV_HEAD: begin
        cmd.trav_head = 1'b1;
        state_next    = stat.head_live ? TRAV_CALC : IDLE;
      end
      TRAV_CALC: begin
        cmd.trav_calc = 1'b1;
        state_next    = TRAV_EMIT;
      end
      TRAV_EMIT: begin
        if (stat.out_free) begin
          cmd.trav_emit = 1'b1;
          state_next    = stat.stage_last ? IDLE : TRAV_CALC;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == TRAV_EMIT && stat.out_free && stat.stage_last) |=> (state == IDLE))
    else $error("chain walk continued past its final entry");

  a_empty_chain: assert property (@(posedge clk) disable iff (rst)
    (state == TRAV_HEAD && !stat.head_live) |=> (state == IDLE && !cmd.trav_emit))
    else $error("empty chain produced a walk");

endmodule

### tb/tb_adjacency_list_store.sv
// Self-checking testbench for the adjacency list graph store.
import als_pkg::*;

typedef struct packed {
  logic [1:0]         kind;
  logic               ok;
  logic [INDEX_W-1:0] node;
  logic [INDEX_W-1:0] target;
  logic [PROD_W-1:0]  comb;
  logic               last;
} store_answer_t;

// Shadow copy of the graph tables plus the answers still owed by the block
class graph_shadow;
  int unsigned node_cap;
  int unsigned edge_cap;
  int unsigned nodes_used;
  int unsigned edges_used;
  int unsigned errors;
  logic signed [SCORE_W-1:0] node_scores[DEF_NODE_DEPTH];
  logic [LINK_W-1:0]         chain_heads[DEF_NODE_DEPTH];
  logic [INDEX_W-1:0]        edge_targets[DEF_EDGE_DEPTH];
  logic signed [SCORE_W-1:0] edge_weights[DEF_EDGE_DEPTH];
  logic [LINK_W-1:0]         edge_links[DEF_EDGE_DEPTH];
  store_answer_t             answers_due[$];

  function new();
    node_cap = NODE_LIMIT_RST;
    edge_cap = EDGE_LIMIT_RST;
    nodes_used = 0;
    edges_used = 0;
    errors = 0;
  endfunction

  function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_NODE_LIMIT) begin
      node_cap = val;
    end else begin
      edge_cap = val[ECOUNT_W-1:0];
    end
  endfunction

  function void queue_answer(logic [1:0] kind, logic ok, logic [INDEX_W-1:0] node,
                             logic [INDEX_W-1:0] target, logic [PROD_W-1:0] comb,
                             logic last);
    store_answer_t a;
    a.kind = kind;
    a.ok = ok;
    a.node = node;
    a.target = target;
    a.comb = comb;
    a.last = last;
    answers_due.push_back(a);
  endfunction

  // Called for every transfer on the input side
  function void apply_item(logic [ACTION_W-1:0] act, logic signed [SCORE_W-1:0] sc,
                           logic [INDEX_W-1:0] src, logic [INDEX_W-1:0] dst,
                           logic signed [SCORE_W-1:0] wt);
    int unsigned nlim;
    int unsigned elim;
    int unsigned e;
    int unsigned steps;
    logic [LINK_W-1:0] link;
    nlim = (node_cap > DEF_NODE_DEPTH) ? DEF_NODE_DEPTH : node_cap;
    elim = (edge_cap > DEF_EDGE_DEPTH) ? DEF_EDGE_DEPTH : edge_cap;
    case (act)
      ACT_ADD_NODE: begin
        if (nodes_used >= nlim) begin
          queue_answer(KIND_NODE, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          node_scores[nodes_used] = sc;
          chain_heads[nodes_used] = '0;
          queue_answer(KIND_NODE, 1'b1, INDEX_W'(nodes_used), '0, '0, 1'b1);
          nodes_used++;
        end
      end
      ACT_ADD_EDGE: begin
        if (src >= nodes_used || dst >= nodes_used || edges_used >= elim) begin
          queue_answer(KIND_EDGE, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          e = edges_used;
          edge_targets[e] = dst;
          edge_weights[e] = wt;
          edge_links[e] = chain_heads[src];
          chain_heads[src] = {1'b1, LINK_IDX_W'(e)};
          edges_used++;
          queue_answer(KIND_EDGE, 1'b1, '0, '0, '0, 1'b1);
        end
      end
      ACT_TRAVERSE: begin
        // newest edge first; top bit of a link marks it live
        if (src < nodes_used) begin
          link = chain_heads[src];
          steps = 0;
          while (link[LINK_W-1] && steps < DEF_EDGE_DEPTH) begin
            e = link[LINK_IDX_W-1:0];
            steps++;
            queue_answer(KIND_NEIGHBOUR, 1'b1, src, edge_targets[e],
                         PROD_W'(int'(node_scores[src]) * int'(edge_weights[e])),
                         !edge_links[e][LINK_W-1] || steps == DEF_EDGE_DEPTH);
            link = edge_links[e];
          end
        end
      end
      default: ;
    endcase
  endfunction

  task flag_mismatch(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task match_answer(store_answer_t got);
    store_answer_t want;
    if (answers_due.size() == 0) begin
      flag_mismatch($sformatf("result with none due: kind %0d node %0d target %0d",
                              got.kind, got.node, got.target));
    end else begin
      want = answers_due.pop_front();
      if (got.kind !== want.kind)
        flag_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
      if (got.ok !== want.ok)
        flag_mismatch($sformatf("ok %0d, want %0d", got.ok, want.ok));
      if (got.node !== want.node)
        flag_mismatch($sformatf("node_index %0d, want %0d", got.node, want.node));
      if (got.target !== want.target)
        flag_mismatch($sformatf("target_index %0d, want %0d", got.target, want.target));
      if (got.comb !== want.comb)
        flag_mismatch($sformatf("weighted_score %0d, want %0d",
                                $signed(got.comb), $signed(want.comb)));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    end
  endtask
endclass

module tb_adjacency_list_store;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 70;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] action = ACT_ADD_NODE;
  logic signed [SCORE_W-1:0] score = '0;
  logic [INDEX_W-1:0] src_index = '0;
  logic [INDEX_W-1:0] dest_index = '0;
  logic signed [SCORE_W-1:0] weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic ok;
  logic [INDEX_W-1:0] node_index;
  logic [INDEX_W-1:0] target_index;
  logic signed [PROD_W-1:0] weighted_score;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  graph_shadow shadow = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  logic long_hold = 1'b0;
  event hold_go;

  adjacency_list_store dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .score(score), .src_index(src_index),
    .dest_index(dest_index), .weight(weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .ok(ok), .node_index(node_index),
    .target_index(target_index), .weighted_score(weighted_score), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    forever begin
      @(hold_go);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      long_hold = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.match_answer({result_kind, ok, node_index, target_index, weighted_score, last});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Entered and left at a falling edge
  task automatic offer_item(input logic [ACTION_W-1:0] act, input logic [SCORE_W-1:0] sc,
                            input logic [INDEX_W-1:0] src, input logic [INDEX_W-1:0] dst,
                            input logic [SCORE_W-1:0] wt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    score <= sc;
    src_index <= src;
    dest_index <= dst;
    weight <= wt;
    do @(posedge clk); while (in_stall);
    shadow.apply_item(act, sc, src, dst, wt);
    @(negedge clk);
  endtask

  // Drain every owed answer, then allow for an item still busy with no output
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.answers_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(input logic [CFG_DATA_W-1:0] n_lim,
                              input logic [CFG_DATA_W-1:0] e_lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NODE_LIMIT;
    cfg_data <= n_lim;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_limit(CFG_NODE_LIMIT, n_lim);
    @(negedge clk);
    cfg_index <= CFG_EDGE_LIMIT;
    cfg_data <= e_lim;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_limit(CFG_EDGE_LIMIT, e_lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly live nodes, with a bias to a few sources so chains grow long
  function automatic logic [INDEX_W-1:0] pick_node();
    int unsigned used;
    used = shadow.nodes_used;
    if (used == 0 || $urandom_range(99) < 12) return INDEX_W'($urandom_range(255));
    if ($urandom_range(99) < 40) return INDEX_W'($urandom_range(used > 4 ? 3 : used - 1));
    return INDEX_W'($urandom_range(used - 1));
  endfunction

  function automatic logic [SCORE_W-1:0] pick_q412();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [ACTION_W-1:0] act;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) act = ACT_ADD_NODE;
    else if (roll < 62) act = ACT_ADD_EDGE;
    else if (roll < 95) act = ACT_TRAVERSE;
    else act = ACT_UNUSED;
    offer_item(act, pick_q412(), pick_node(), pick_node(), pick_q412());
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] n_lim,
                           input logic [CFG_DATA_W-1:0] e_lim,
                           input int unsigned s_idle, input int unsigned r_stall,
                           input bit squeeze);
    settle();
    write_limits(n_lim, e_lim);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    if (squeeze) -> hold_go;
    repeat (PHASE_ITEMS) send_random();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // both limits at zero: every add refused, nothing to walk
    write_limits(9'd0, 9'd0);
    offer_item(ACT_ADD_NODE, 16'h7fff, 8'd0, 8'd0, 16'h0001);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd0, 8'd0, 16'h0001);
    offer_item(ACT_TRAVERSE, 16'h0000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_UNUSED, 16'hffff, 8'hff, 8'hff, 16'hffff);
    settle();

    // three nodes, two edges: full tables, bad indices, extreme products
    write_limits(9'd3, 9'd2);
    offer_item(ACT_ADD_NODE, 16'h8000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_ADD_NODE, 16'h7fff, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_ADD_NODE, 16'h0000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_ADD_NODE, 16'h1000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_TRAVERSE, 16'h0000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd3, 8'd0, 16'h1000);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd0, 8'hff, 16'h1000);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd0, 8'd1, 16'h8000);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd0, 8'd2, 16'h7fff);
    offer_item(ACT_ADD_EDGE, 16'h0000, 8'd1, 8'd0, 16'h0001);
    offer_item(ACT_TRAVERSE, 16'h0000, 8'd0, 8'd0, 16'h0000);
    offer_item(ACT_TRAVERSE, 16'h0000, 8'hff, 8'd0, 16'h0000);
    offer_item(ACT_TRAVERSE, 16'h0000, 8'd2, 8'd0, 16'h0000);

    run_phase(9'd256, 9'd24, 0, 0, 1'b0);
    run_phase(9'd60, 9'd40, 74, 0, 1'b0);
    run_phase(9'd511, 9'd127, 0, 74, 1'b0);
    run_phase(9'd256, 9'd64, 18, 18, 1'b0);
    run_phase(9'd300, 9'd100, 0, 0, 1'b1);

    settle();
    if (shadow.errors == 0 && shadow.answers_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

### sim.f
rtl/als_pkg.sv
rtl/als_ram.sv
rtl/als_dp.sv
rtl/als_ctrl.sv
rtl/adjacency_list_store.sv
tb/tb_adjacency_list_store.sv
